// ----- hw/rtl/pc_pkg.sv -----
`default_nettype none

package pc_pkg;

    // Longest run that is accumulated; further pairs of a run are ignored.
    localparam int MAX_RUN_LENGTH = 4096;

    localparam int COUNT_W = $clog2(MAX_RUN_LENGTH + 1);
    localparam int LG_MAX  = $clog2(MAX_RUN_LENGTH);

    // Accumulator widths: sum of x or y, sum of x*y (signed), sum of squares.
    localparam int SX_W  = LG_MAX + 16;
    localparam int SXY_W = LG_MAX + 32;
    localparam int SQ_W  = LG_MAX + 31;

    // Width of the n*S - S*S terms, kept even so the root has TERM_W/2 bits.
    localparam int TERM_W = 2 * ((COUNT_W + SXY_W + 2) / 2);
    localparam int ROOT_W = TERM_W / 2;

    // Fractional bits of the coefficient plus the integer bit.
    localparam int QUOT_W = 16;

    typedef struct packed {
        logic [COUNT_W-1:0]      count;
        logic signed [SX_W-1:0]  sx;
        logic signed [SX_W-1:0]  sy;
        logic signed [SXY_W-1:0] sxy;
        logic [SQ_W-1:0]         sxx;
        logic [SQ_W-1:0]         syy;
    } pc_sums_t;

    typedef struct packed {
        logic full;
        logic empty;
    } pc_queue_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/pc_front.sv -----
`default_nettype none

module pc_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic signed [15:0] x_sample,
    input  wire logic signed [15:0] y_sample,
    input  wire logic              last_sample,
    input  wire pc_pkg::pc_queue_stat_t q_stat,
    output logic                   push,
    output pc_pkg::pc_sums_t       sums
);

    logic                     st1_valid_reg;
    logic signed [15:0]       x_reg;
    logic signed [15:0]       y_reg;
    logic                     last_reg;
    logic signed [31:0]       xy_reg;
    logic [30:0]              xx_reg;
    logic [30:0]              yy_reg;

    logic signed [31:0]       xy_prod;
    logic signed [31:0]       xx_prod;
    logic signed [31:0]       yy_prod;

    logic [pc_pkg::COUNT_W-1:0]      count_reg;
    logic signed [pc_pkg::SX_W-1:0]  sum_x_reg;
    logic signed [pc_pkg::SX_W-1:0]  sum_y_reg;
    logic signed [pc_pkg::SXY_W-1:0] sum_xy_reg;
    logic [pc_pkg::SQ_W-1:0]         sum_xx_reg;
    logic [pc_pkg::SQ_W-1:0]         sum_yy_reg;

    logic    go;
    logic    keep;
    pc_pkg::pc_sums_t sums_next;

    assign xy_prod = x_sample * y_sample;
    assign xx_prod = x_sample * x_sample;
    assign yy_prod = y_sample * y_sample;

    // The products stage advances unless a closing pair meets a full queue.
    assign go       = st1_valid_reg && !(last_reg && q_stat.full);
    assign in_ready = !st1_valid_reg || go;
    assign keep     = count_reg < pc_pkg::COUNT_W'(pc_pkg::MAX_RUN_LENGTH);

    always_comb
    begin
        sums_next.count = count_reg;
        sums_next.sx    = sum_x_reg;
        sums_next.sy    = sum_y_reg;
        sums_next.sxy   = sum_xy_reg;
        sums_next.sxx   = sum_xx_reg;
        sums_next.syy   = sum_yy_reg;
        if (keep)
        begin
            sums_next.count = count_reg + 1'b1;
            sums_next.sx    = sum_x_reg + pc_pkg::SX_W'(x_reg);
            sums_next.sy    = sum_y_reg + pc_pkg::SX_W'(y_reg);
            sums_next.sxy   = sum_xy_reg + pc_pkg::SXY_W'(xy_reg);
            sums_next.sxx   = sum_xx_reg + pc_pkg::SQ_W'(xx_reg);
            sums_next.syy   = sum_yy_reg + pc_pkg::SQ_W'(yy_reg);
        end
    end

    assign push = go && last_reg;
    assign sums = sums_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            st1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            x_reg    <= x_sample;
            y_reg    <= y_sample;
            last_reg <= last_sample;
            xy_reg   <= xy_prod;
            xx_reg   <= xx_prod[30:0];
            yy_reg   <= yy_prod[30:0];
        end
    end

    // A closing pair hands its sums to the queue and clears the accumulators.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            sum_x_reg  <= '0;
            sum_y_reg  <= '0;
            sum_xy_reg <= '0;
            sum_xx_reg <= '0;
            sum_yy_reg <= '0;
        end
        else if (go)
        begin
            if (last_reg)
            begin
                count_reg  <= '0;
                sum_x_reg  <= '0;
                sum_y_reg  <= '0;
                sum_xy_reg <= '0;
                sum_xx_reg <= '0;
                sum_yy_reg <= '0;
            end
            else
            begin
                count_reg  <= sums_next.count;
                sum_x_reg  <= sums_next.sx;
                sum_y_reg  <= sums_next.sy;
                sum_xy_reg <= sums_next.sxy;
                sum_xx_reg <= sums_next.sxx;
                sum_yy_reg <= sums_next.syy;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/pc_queue.sv -----
`default_nettype none

module pc_queue (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  wire pc_pkg::pc_sums_t       wr_data,
    input  wire logic                   pop,
    output pc_pkg::pc_sums_t            rd_data,
    output pc_pkg::pc_queue_stat_t      stat
);

    pc_pkg::pc_sums_t slot_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       fill_reg;

    assign stat.full  = fill_reg == 2'd2;
    assign stat.empty = fill_reg == 2'd0;
    assign rd_data    = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/pc_back.sv -----
`default_nettype none

module pc_back (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire pc_pkg::pc_queue_stat_t q_stat,
    input  wire pc_pkg::pc_sums_t       sums,
    output logic                        pop,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic signed [15:0]          coefficient,
    output logic                        degenerate
);

    localparam int TW    = pc_pkg::TERM_W;
    localparam int RW    = pc_pkg::ROOT_W;
    localparam int QW    = pc_pkg::QUOT_W;
    localparam int SX_W  = pc_pkg::SX_W;
    localparam int STEP_W = $clog2(RW + 1);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MULN,
        ST_SQR,
        ST_DIFF,
        ST_ZCHK,
        ST_ROOT,
        ST_DEN,
        ST_DCHK,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t              state_reg;
    logic [STEP_W-1:0]   step_reg;
    logic                out_valid_reg;
    logic signed [15:0]  coef_reg;
    logic                deg_reg;

    // Datapath registers.
    logic [pc_pkg::COUNT_W-1:0] n_reg;
    logic signed [SX_W-1:0]     sx_reg;
    logic signed [SX_W-1:0]     sy_reg;
    logic signed [TW-1:0]       mc_xx_reg;
    logic signed [TW-1:0]       mc_yy_reg;
    logic signed [TW-1:0]       mc_xy_reg;
    logic signed [TW-1:0]       acc_xx_reg;
    logic signed [TW-1:0]       acc_yy_reg;
    logic signed [TW-1:0]       acc_xy_reg;
    logic signed [TW-1:0]       sq_xx_reg;
    logic signed [TW-1:0]       sq_yy_reg;
    logic signed [TW-1:0]       sq_xy_reg;
    logic [TW-1:0]              vx_reg;
    logic [TW-1:0]              vy_reg;
    logic signed [TW-1:0]       num_reg;
    logic [TW-1:0]              mag_reg;
    logic                       neg_reg;
    logic                       zero_reg;
    logic [RW+1:0]              rr_x_reg;
    logic [RW+1:0]              rr_y_reg;
    logic [RW-1:0]              rt_x_reg;
    logic [RW-1:0]              rt_y_reg;
    logic [TW-1:0]              den_reg;
    logic                       sat_reg;
    logic [TW:0]                rem_reg;
    logic [QW-1:0]              q_reg;

    logic signed [SX_W-1:0]     mul_a;
    logic signed [SX_W-1:0]     mul_b;
    logic signed [2*SX_W-1:0]   mul_p;
    logic [RW+1:0]              rem_x_n;
    logic [RW+1:0]              rem_y_n;
    logic [RW+1:0]              trial_x;
    logic [RW+1:0]              trial_y;
    logic                       ge_x;
    logic                       ge_y;
    logic [TW:0]                cand;
    logic                       ge_d;
    logic signed [15:0]         coef_calc;

    assign pop         = (state_reg == ST_IDLE) && !q_stat.empty;
    assign out_valid   = out_valid_reg;
    assign coefficient = coef_reg;
    assign degenerate  = deg_reg;

    // One shared multiplier forms Sx*Sx, Sy*Sy and Sx*Sy on successive cycles.
    always_comb
    begin
        case (step_reg)
            STEP_W'(0):
            begin
                mul_a = sx_reg;
                mul_b = sx_reg;
            end
            STEP_W'(1):
            begin
                mul_a = sy_reg;
                mul_b = sy_reg;
            end
            default:
            begin
                mul_a = sx_reg;
                mul_b = sy_reg;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // One result bit per cycle for each square root.
    assign rem_x_n = {rr_x_reg[RW-1:0], vx_reg[TW-1:TW-2]};
    assign rem_y_n = {rr_y_reg[RW-1:0], vy_reg[TW-1:TW-2]};
    assign trial_x = {rt_x_reg, 2'b01};
    assign trial_y = {rt_y_reg, 2'b01};
    assign ge_x    = rem_x_n >= trial_x;
    assign ge_y    = rem_y_n >= trial_y;

    // Restoring division: the first step gives the integer bit, the rest fractions.
    assign cand = (step_reg == '0) ? rem_reg : {rem_reg[TW-1:0], 1'b0};
    assign ge_d = cand >= {1'b0, den_reg};

    always_comb
    begin
        if (zero_reg)
        begin
            coef_calc = '0;
        end
        else if (neg_reg)
        begin
            if (sat_reg || q_reg[QW-1])
            begin
                coef_calc = 16'sh8000;
            end
            else
            begin
                coef_calc = -$signed(q_reg);
            end
        end
        else
        begin
            if (sat_reg || (q_reg >= QW'(32767)))
            begin
                coef_calc = 16'sh7fff;
            end
            else
            begin
                coef_calc = $signed(q_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            coef_reg      <= '0;
            deg_reg       <= 1'b0;
        end
        else
        begin
            // In ST_OUT the output register is reloaded below instead.
            if (out_valid_reg && out_ready && (state_reg != ST_OUT))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    step_reg <= '0;
                    if (pop)
                    begin
                        state_reg <= ST_MULN;
                    end
                end
                ST_MULN:
                begin
                    if (step_reg == STEP_W'(pc_pkg::COUNT_W - 1))
                    begin
                        step_reg  <= '0;
                        state_reg <= ST_SQR;
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                ST_SQR:
                begin
                    if (step_reg == STEP_W'(2))
                    begin
                        step_reg  <= '0;
                        state_reg <= ST_DIFF;
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                ST_DIFF:
                begin
                    state_reg <= ST_ZCHK;
                end
                ST_ZCHK:
                begin
                    step_reg <= '0;
                    if ((vx_reg == '0) || (vy_reg == '0))
                    begin
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        state_reg <= ST_ROOT;
                    end
                end
                ST_ROOT:
                begin
                    if (step_reg == STEP_W'(RW - 1))
                    begin
                        step_reg  <= '0;
                        state_reg <= ST_DEN;
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                ST_DEN:
                begin
                    state_reg <= ST_DCHK;
                end
                ST_DCHK:
                begin
                    step_reg  <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (step_reg == STEP_W'(QW - 1))
                    begin
                        step_reg  <= '0;
                        state_reg <= ST_OUT;
                    end
                    else
                    begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                ST_OUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        coef_reg      <= coef_calc;
                        deg_reg       <= zero_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    n_reg      <= sums.count;
                    sx_reg     <= sums.sx;
                    sy_reg     <= sums.sy;
                    mc_xx_reg  <= TW'(sums.sxx);
                    mc_yy_reg  <= TW'(sums.syy);
                    mc_xy_reg  <= TW'(sums.sxy);
                    acc_xx_reg <= '0;
                    acc_yy_reg <= '0;
                    acc_xy_reg <= '0;
                end
            end
            ST_MULN:
            begin
                // n times each sum, one bit of n per cycle.
                if (n_reg[0])
                begin
                    acc_xx_reg <= acc_xx_reg + mc_xx_reg;
                    acc_yy_reg <= acc_yy_reg + mc_yy_reg;
                    acc_xy_reg <= acc_xy_reg + mc_xy_reg;
                end
                mc_xx_reg <= mc_xx_reg <<< 1;
                mc_yy_reg <= mc_yy_reg <<< 1;
                mc_xy_reg <= mc_xy_reg <<< 1;
                n_reg     <= n_reg >> 1;
            end
            ST_SQR:
            begin
                case (step_reg)
                    STEP_W'(0): sq_xx_reg <= TW'(mul_p);
                    STEP_W'(1): sq_yy_reg <= TW'(mul_p);
                    default:    sq_xy_reg <= TW'(mul_p);
                endcase
            end
            ST_DIFF:
            begin
                vx_reg  <= unsigned'(acc_xx_reg - sq_xx_reg);
                vy_reg  <= unsigned'(acc_yy_reg - sq_yy_reg);
                num_reg <= acc_xy_reg - sq_xy_reg;
            end
            ST_ZCHK:
            begin
                neg_reg  <= num_reg[TW-1];
                mag_reg  <= num_reg[TW-1] ? unsigned'(-num_reg) : unsigned'(num_reg);
                zero_reg <= (vx_reg == '0) || (vy_reg == '0);
                rr_x_reg <= '0;
                rr_y_reg <= '0;
                rt_x_reg <= '0;
                rt_y_reg <= '0;
            end
            ST_ROOT:
            begin
                rr_x_reg <= ge_x ? (rem_x_n - trial_x) : rem_x_n;
                rr_y_reg <= ge_y ? (rem_y_n - trial_y) : rem_y_n;
                rt_x_reg <= {rt_x_reg[RW-2:0], ge_x};
                rt_y_reg <= {rt_y_reg[RW-2:0], ge_y};
                vx_reg   <= vx_reg << 2;
                vy_reg   <= vy_reg << 2;
            end
            ST_DEN:
            begin
                den_reg <= rt_x_reg * rt_y_reg;
            end
            ST_DCHK:
            begin
                sat_reg <= {1'b0, mag_reg} >= {den_reg, 1'b0};
                rem_reg <= {1'b0, mag_reg};
                q_reg   <= '0;
            end
            ST_DIV:
            begin
                rem_reg <= ge_d ? (cand - {1'b0, den_reg}) : cand;
                q_reg   <= {q_reg[QW-2:0], ge_d};
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hw/rtl/pearson_correlation.sv -----
// Pearson correlation of a run of paired Q15 samples.
//
// Input channel (s_*): one beat carries one sample pair. s_tdata holds x in
// bits 15:0 and y in bits 31:16, both signed Q15; s_tlast marks the final
// pair of a run. Pairs are taken at one beat per clock while s_tready is
// high. Beyond the configured maximum run length, further pairs of a run are
// dropped, but a closing pair still ends the run.
//
// Output channel (m_*): one beat per run. m_tdata is the coefficient in
// signed Q1.15, with +1 reading as 32767; m_tuser is set, and the coefficient
// is zero, when either variance term is zero.
//
// The accumulator takes one pair a cycle while s_tready is high. The result
// engine takes a run from the queue only when idle; its time per run is set
// by the bit-serial multiply by n, the two square roots taken a bit per
// cycle and the sixteen-step divider, and a zero variance skips the roots
// and the divider. A two-entry queue holds finished sums, so runs overlap
// the engine; s_tready falls only when a closing pair finds the queue full.
//
// Reset clears the accumulators, the queue and the engine. If the receiver
// stalls, the output register holds the result; the engine waits in ST_OUT.
`default_nettype none

module pearson_correlation (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // x_sample [15:0], y_sample [31:16]
    input  wire logic        s_tlast,   // last_sample
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // coefficient [15:0]
    output logic [0:0]       m_tuser    // degenerate [0]
);

    pc_pkg::pc_queue_stat_t q_stat;
    pc_pkg::pc_sums_t       push_sums;
    pc_pkg::pc_sums_t       pop_sums;
    logic                   push;
    logic                   pop;
    logic signed [15:0]     coefficient;
    logic                   degenerate;

    // Front end: products stage and the running sums.
    pc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .x_sample    ($signed(s_tdata[15:0])),
        .y_sample    ($signed(s_tdata[31:16])),
        .last_sample (s_tlast),
        .q_stat      (q_stat),
        .push        (push),
        .sums        (push_sums)
    );

    // Finished runs wait here for the result engine.
    pc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (push_sums),
        .pop     (pop),
        .rd_data (pop_sums),
        .stat    (q_stat)
    );

    // Result engine: variance terms, square roots, division and saturation.
    pc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_stat      (q_stat),
        .sums        (pop_sums),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .coefficient (coefficient),
        .degenerate  (degenerate)
    );

    assign m_tdata    = coefficient;
    assign m_tuser[0] = degenerate;

    // The front end must never push into a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_stat.full)
        else $error("queue written while full");

    // The engine must never take from an empty queue.
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("queue read while empty");

    // A degenerate result always carries a zero coefficient.
    a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == 16'd0))
        else $error("degenerate result with non-zero coefficient");

    // A closing beat that is accepted reaches the queue on the next edge
    // unless the queue is full at that point.
    a_close_pushes: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> (push || q_stat.full))
        else $error("closing pair did not reach the queue");

endmodule

`default_nettype wire
